/* rtl/tccw_pkg.sv */
// Package: shared types and constants for the text console cell writer.
package tccw_pkg;

  localparam int MaxColumns = 80;
  localparam int MaxRows    = 25;
  localparam int PageCount  = 4;
  localparam int TabStop    = 8;

  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChTab   = 8'd9;

  localparam logic [2:0] RegColumnCount = 3'd0;
  localparam logic [2:0] RegRowCount    = 3'd1;
  localparam logic [2:0] RegViewTop     = 3'd2;
  localparam logic [2:0] RegViewBottom  = 3'd3;
  localparam logic [2:0] RegForeColor   = 3'd4;
  localparam logic [2:0] RegBackColor   = 3'd5;
  localparam logic [2:0] RegActivePage  = 3'd6;

  typedef enum logic [3:0] {
    ST_CLEAR,     // reset sweep over the whole store
    ST_IDLE,
    ST_DECODE,    // look at the item
    ST_READ,      // wait for registered read data
    ST_PUT,       // store one printable cell, advance cursor
    ST_SCR_RD,    // read cell of row below
    ST_SCR_WR,    // write it one row up
    ST_BLANK,     // clear last view row
    ST_RESULT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;     // write blank at clear counter, advance it
    logic capture;      // latch input item
    logic do_read;      // issue cell read for read item
    logic put_cell;     // write printable at cursor, advance cursor
    logic cr;
    logic lf;
    logic bs;
    logic tab_init;     // load tab count
    logic scroll_init;  // start scroll sweep
    logic scr_read;
    logic scr_write;
    logic blank_write;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic is_read;
    logic is_cr;
    logic is_lf;
    logic is_bs;
    logic is_tab;
    logic is_print;
    logic tab_more;     // more tab spaces remain after the current one
    logic need_scroll;  // cursor now below view bottom
    logic scroll_ok;    // view region and page valid for copying
    logic copy_last;    // current copy is last of the sweep
    logic blank_last;   // current blank is last of the row
  } sts_t;

endpackage

/* rtl/text_console_cell_writer.sv */
// Top level: text console cell writer, controller plus datapath.
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready
//  out     | output    | out_valid / out_ready
//  cfg     | input     | cfg_valid / cfg_ready, index and data
// After a transfer, CR, BS and ignored bytes go straight to the result, reads wait for
// the cell read, and printable bytes and LF pass the put step (one cell, or up to TAB_STOP for a tab).
// A scroll copies each view cell one row up by a read and then a write, then blanks the last view row.
// After reset a clear pass over all PAGE_COUNT*MAX_ROWS*MAX_COLUMNS cells runs before
// the first item is taken. A result waits in its register while out_ready is low.
module text_console_cell_writer #(
  parameter int MAX_COLUMNS = tccw_pkg::MaxColumns,
  parameter int MAX_ROWS    = tccw_pkg::MaxRows,
  parameter int PAGE_COUNT  = tccw_pkg::PageCount,
  parameter int TAB_STOP    = tccw_pkg::TabStop
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func_i,
  input  logic [7:0] character_i,
  input  logic [1:0] read_page_i,
  input  logic [6:0] read_column_i,
  input  logic [4:0] read_row_i,
  input  logic       last_of_text_i,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] cell_character_o,
  output logic [7:0] cell_attribute_o,
  output logic       cell_valid_o,
  output logic [6:0] cursor_column_o,
  output logic [4:0] cursor_row_o,
  output logic       end_flag_o,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);

  tccw_pkg::cmd_t cmd;
  tccw_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tccw_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .PAGE_COUNT  (PAGE_COUNT),
    .TAB_STOP    (TAB_STOP)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid),
    .cfg_idx_i        (cfg_index),
    .cfg_data_i       (cfg_data),
    .func_i           (func_i),
    .character_i      (character_i),
    .read_page_i      (read_page_i),
    .read_column_i    (read_column_i),
    .read_row_i       (read_row_i),
    .last_of_text_i   (last_of_text_i),
    .cell_character_o (cell_character_o),
    .cell_attribute_o (cell_attribute_o),
    .cell_valid_o     (cell_valid_o),
    .cursor_column_o  (cursor_column_o),
    .cursor_row_o     (cursor_row_o),
    .end_flag_o       (end_flag_o)
  );

endmodule

/* rtl/tccw_ctrl.sv */
// Controller: sequences clear sweep, character handling, scrolling and results.
module tccw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tccw_pkg::sts_t       sts_i,
  output tccw_pkg::cmd_t       cmd_o
);

  tccw_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // output slot frees when taken, so a new item may start while one waits
  logic slot_free;
  assign slot_free = !out_valid_q || out_ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tccw_pkg::ST_CLEAR:  if (sts_i.clr_done) state_d = tccw_pkg::ST_IDLE;
      tccw_pkg::ST_IDLE:   if (in_valid) state_d = tccw_pkg::ST_DECODE;
      tccw_pkg::ST_DECODE: begin
        if (sts_i.is_read) state_d = tccw_pkg::ST_READ;
        else if (sts_i.is_print || sts_i.is_tab) state_d = tccw_pkg::ST_PUT;
        else state_d = tccw_pkg::ST_RESULT;
      end
      tccw_pkg::ST_READ:   state_d = tccw_pkg::ST_RESULT;
      tccw_pkg::ST_PUT: begin
        if (sts_i.need_scroll) begin
          state_d = sts_i.scroll_ok ? (sts_i.copy_last ? tccw_pkg::ST_BLANK
                                                       : tccw_pkg::ST_SCR_RD)
                                    : (sts_i.tab_more ? tccw_pkg::ST_PUT
                                                      : tccw_pkg::ST_RESULT);
        end else if (!sts_i.tab_more) begin
          state_d = tccw_pkg::ST_RESULT;
        end
      end
      tccw_pkg::ST_SCR_RD: state_d = tccw_pkg::ST_SCR_WR;
      tccw_pkg::ST_SCR_WR: if (sts_i.copy_last) state_d = tccw_pkg::ST_BLANK;
                           else state_d = tccw_pkg::ST_SCR_RD;
      tccw_pkg::ST_BLANK: begin
        if (sts_i.blank_last)
          state_d = sts_i.tab_more ? tccw_pkg::ST_PUT : tccw_pkg::ST_RESULT;
      end
      tccw_pkg::ST_RESULT: if (slot_free) state_d = tccw_pkg::ST_IDLE;
      default: state_d = tccw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    case (state_q)
      tccw_pkg::ST_CLEAR:  cmd_o.clr_step = 1'b1;
      tccw_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.capture = in_valid;
      end
      tccw_pkg::ST_DECODE: begin
        cmd_o.do_read     = sts_i.is_read;
        cmd_o.cr          = sts_i.is_cr;
        cmd_o.bs          = sts_i.is_bs;
        cmd_o.tab_init    = sts_i.is_tab;
        // LF goes through the put step without storing
        cmd_o.lf          = sts_i.is_lf;
      end
      tccw_pkg::ST_PUT: begin
        cmd_o.put_cell    = 1'b1;
        cmd_o.scroll_init = sts_i.need_scroll && sts_i.scroll_ok;
      end
      tccw_pkg::ST_SCR_RD: cmd_o.scr_read = 1'b1;
      tccw_pkg::ST_SCR_WR: cmd_o.scr_write = 1'b1;
      tccw_pkg::ST_BLANK:  cmd_o.blank_write = 1'b1;
      tccw_pkg::ST_RESULT: cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end
  assign out_valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccw_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result not presented");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccw_pkg::ST_CLEAR) |-> !in_ready)
    else $error("item accepted during clear");
  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == tccw_pkg::ST_IDLE))
    else $error("no return to idle");

endmodule

/* rtl/tccw_datapath.sv */
// Datapath: cell memory, cursor, configuration registers and result register.
module tccw_datapath #(
  parameter int MAX_COLUMNS = tccw_pkg::MaxColumns,
  parameter int MAX_ROWS    = tccw_pkg::MaxRows,
  parameter int PAGE_COUNT  = tccw_pkg::PageCount,
  parameter int TAB_STOP    = tccw_pkg::TabStop
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tccw_pkg::cmd_t cmd_i,
  output tccw_pkg::sts_t sts_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [6:0]     cfg_data_i,
  input  logic           func_i,
  input  logic [7:0]     character_i,
  input  logic [1:0]     read_page_i,
  input  logic [6:0]     read_column_i,
  input  logic [4:0]     read_row_i,
  input  logic           last_of_text_i,
  output logic [7:0]     cell_character_o,
  output logic [7:0]     cell_attribute_o,
  output logic           cell_valid_o,
  output logic [6:0]     cursor_column_o,
  output logic [4:0]     cursor_row_o,
  output logic           end_flag_o
);

  localparam int Cells = PAGE_COUNT * MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int TW    = $clog2(TAB_STOP + 1);
  localparam logic [15:0] BlankReset = 16'h0720;

  // configuration
  logic [6:0] col_cnt_q;
  logic [4:0] row_cnt_q, vtop_q, vbot_q;
  logic [3:0] fore_q, back_q;
  logic [1:0] page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= 7'd80;
      row_cnt_q <= 5'd25;
      vtop_q    <= 5'd0;
      vbot_q    <= 5'd24;
      fore_q    <= 4'd7;
      back_q    <= 4'd0;
      page_q    <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tccw_pkg::RegColumnCount: col_cnt_q <= cfg_data_i;
        tccw_pkg::RegRowCount:    row_cnt_q <= cfg_data_i[4:0];
        tccw_pkg::RegViewTop:     vtop_q    <= cfg_data_i[4:0];
        tccw_pkg::RegViewBottom:  vbot_q    <= cfg_data_i[4:0];
        tccw_pkg::RegForeColor:   fore_q    <= cfg_data_i[3:0];
        tccw_pkg::RegBackColor:   back_q    <= cfg_data_i[3:0];
        tccw_pkg::RegActivePage:  page_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // saturated counts and clamped bottom
  logic [CW-1:0] cols;
  logic [RW-1:0] rows;
  logic [RW-1:0] bot;
  logic          page_ok;
  logic [7:0]    attr;
  always_comb begin
    if (col_cnt_q == 7'd0) cols = CW'(1);
    else if (32'(col_cnt_q) > MAX_COLUMNS) cols = CW'(MAX_COLUMNS);
    else cols = CW'(col_cnt_q);
    if (row_cnt_q == 5'd0) rows = RW'(1);
    else if (32'(row_cnt_q) > MAX_ROWS) rows = RW'(MAX_ROWS);
    else rows = RW'(row_cnt_q);
    if (32'(vbot_q) >= 32'(rows)) bot = rows - RW'(1);
    else bot = RW'(vbot_q);
  end
  assign page_ok = 32'(page_q) < PAGE_COUNT;
  assign attr    = {back_q, fore_q};

  // captured item
  logic       func_q, last_q;
  logic [7:0] ch_q;
  logic [1:0] rp_q;
  logic [6:0] rc_q;
  logic [4:0] rr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      ch_q   <= character_i;
      rp_q   <= read_page_i;
      rc_q   <= read_column_i;
      rr_q   <= read_row_i;
      last_q <= last_of_text_i;
    end
  end

  // cursor (wide enough to step one past the count before wrap)
  logic [CW:0] ccol_q, ccol_d;
  logic [RW:0] crow_q, crow_d;
  logic [TW-1:0] tab_q, tab_d;
  logic          lf_mode_q, lf_mode_d;

  logic          cur_in;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_wr;
  logic          wrap;
  assign cur_in  = 32'(ccol_q) < 32'(cols) && 32'(crow_q) < 32'(rows);
  assign col_inc = lf_mode_q ? (CW+1)'(cols) : ccol_q + (CW+1)'(1);
  assign wrap    = 32'(col_inc) >= 32'(cols);
  assign row_wr  = wrap ? crow_q + (RW+1)'(1) : crow_q;

  // scroll sweep
  logic [RW-1:0] sr_q, sr_d;
  logic [CW-1:0] sc_q, sc_d;
  logic          copy_empty;
  assign copy_empty = !(32'(vtop_q) < 32'(bot));

  always_comb begin
    ccol_d    = ccol_q;
    crow_d    = crow_q;
    tab_d     = tab_q;
    lf_mode_d = lf_mode_q;
    sr_d      = sr_q;
    sc_d      = sc_q;
    if (cmd_i.cr) ccol_d = '0;
    if (cmd_i.bs && ccol_q != '0) ccol_d = ccol_q - (CW+1)'(1);
    if (cmd_i.tab_init) begin
      tab_d     = TW'(TAB_STOP - (32'(ccol_q) % TAB_STOP));
      lf_mode_d = 1'b0;
    end
    if (cmd_i.lf) begin
      tab_d     = TW'(1);
      lf_mode_d = 1'b1;
    end
    if (cmd_i.capture && func_i == 1'b0 && character_i >= tccw_pkg::ChSpace) begin
      tab_d     = TW'(1);
      lf_mode_d = 1'b0;
    end
    if (cmd_i.put_cell) begin
      tab_d  = tab_q - TW'(1);
      ccol_d = wrap ? '0 : col_inc;
      crow_d = (32'(row_wr) > 32'(bot)) ? (RW+1)'(bot) : row_wr;
    end
    if (cmd_i.scroll_init) begin
      sr_d = RW'(vtop_q);
      sc_d = '0;
    end
    if (cmd_i.scr_write || cmd_i.blank_write) begin
      if (32'(sc_q) + 1 >= 32'(cols)) begin
        sc_d = '0;
        sr_d = sr_q + RW'(1);
      end else begin
        sc_d = sc_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccol_q    <= '0;
      crow_q    <= '0;
      tab_q     <= '0;
      lf_mode_q <= 1'b0;
      sr_q      <= '0;
      sc_q      <= '0;
    end else begin
      ccol_q    <= ccol_d;
      crow_q    <= crow_d;
      tab_q     <= tab_d;
      lf_mode_q <= lf_mode_d;
      sr_q      <= sr_d;
      sc_q      <= sc_d;
    end
  end

  // clear sweep counter
  logic [AW-1:0] clr_q;
  logic          clr_done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clr_step) begin
      if (32'(clr_q) == Cells - 1) clr_done_q <= 1'b1;
      else clr_q <= clr_q + AW'(1);
    end
  end

  // address of (page,row,col)
  function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p,
                                            input logic [RW-1:0] r,
                                            input logic [CW-1:0] c);
    addr_of = AW'(32'(p) * (MAX_ROWS * MAX_COLUMNS) + 32'(r) * MAX_COLUMNS + 32'(c));
  endfunction

  logic [PW-1:0] apage;
  assign apage = PW'(page_q);

  // memory ports
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [15:0]   wd;
  logic          re;
  logic [15:0]   rdata_q;
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = {attr, ch_q};
    re = 1'b0;
    ra = addr_of(PW'(rp_q), RW'(rr_q), CW'(rc_q));
    if (cmd_i.clr_step) begin
      we = 1'b1;
      wa = clr_q;
      wd = BlankReset;
    end else if (cmd_i.put_cell) begin
      we = !lf_mode_q && page_ok && cur_in;
      wa = addr_of(apage, RW'(crow_q), CW'(ccol_q));
      wd = {attr, (ch_q == tccw_pkg::ChTab) ? tccw_pkg::ChSpace : ch_q};
    end else if (cmd_i.scr_write) begin
      we = 1'b1;
      wa = addr_of(apage, sr_q, sc_q);
      wd = rdata_q;
    end else if (cmd_i.blank_write) begin
      we = 1'b1;
      wa = addr_of(apage, bot, sc_q);
      wd = {attr, tccw_pkg::ChSpace};
    end
    if (cmd_i.do_read) re = 1'b1;
    if (cmd_i.scr_read) begin
      re = 1'b1;
      ra = addr_of(apage, sr_q + RW'(1), sc_q);
    end
  end

  logic [15:0] mem [Cells];
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
  end
  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= mem[ra];
  end

  logic rd_ok;
  assign rd_ok = 32'(rp_q) < PAGE_COUNT && 32'(rc_q) < 32'(cols) && 32'(rr_q) < 32'(rows);

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cell_character_o <= (func_q && rd_ok) ? rdata_q[7:0] : 8'd0;
      cell_attribute_o <= (func_q && rd_ok) ? rdata_q[15:8] : 8'd0;
      cell_valid_o     <= func_q && rd_ok;
      cursor_column_o  <= 7'(ccol_q);
      cursor_row_o     <= 5'(crow_q);
      end_flag_o       <= last_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_done   = clr_done_q;
    sts_o.is_read    = func_q;
    sts_o.is_cr      = !func_q && ch_q == tccw_pkg::ChCr;
    sts_o.is_lf      = !func_q && ch_q == tccw_pkg::ChLf;
    sts_o.is_bs      = !func_q && ch_q == tccw_pkg::ChBs;
    sts_o.is_tab     = !func_q && ch_q == tccw_pkg::ChTab;
    sts_o.is_print   = !func_q && (ch_q >= tccw_pkg::ChSpace || ch_q == tccw_pkg::ChLf);
    // after a scroll the count has already dropped for the cell just put
    sts_o.tab_more   = cmd_i.put_cell ? (tab_q > TW'(1)) : (tab_q != '0);
    sts_o.need_scroll = 32'(row_wr) > 32'(bot);
    sts_o.scroll_ok  = page_ok && !(32'(vtop_q) > 32'(bot));
    // in the put state copy_last means the copy part is empty
    sts_o.copy_last  = cmd_i.put_cell ? copy_empty
                     : (32'(sr_q) + 1 >= 32'(bot) && 32'(sc_q) + 1 >= 32'(cols));
    sts_o.blank_last = 32'(sc_q) + 1 >= 32'(cols);
  end

  a_cursor_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put_cell |=> 32'(crow_q) <= 32'(MAX_ROWS))
    else $error("cursor row out of range");
  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> !we)
    else $error("write during accept");
  a_clear_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_done_q |=> clr_done_q)
    else $error("clear done dropped");

endmodule
